>>> src/gda_pkg.sv
// Package holding the types, constants and calendar functions of the date calculator.
`default_nettype none
package gda_pkg;

   localparam int MaxYear = 9999;

   localparam logic [2:0] MODE_ADD  = 3'd0;
   localparam logic [2:0] MODE_SUB  = 3'd1;
   localparam logic [2:0] MODE_DIFF = 3'd2;
   localparam logic [2:0] MODE_D2N  = 3'd3;
   localparam logic [2:0] MODE_N2D  = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BAD   = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic [1:0] ORD_EQ    = 2'd0;
   localparam logic [1:0] ORD_LATER = 2'd1;
   localparam logic [1:0] ORD_EARLY = 2'd2;

   localparam int YP = MaxYear - 1;
   localparam logic [22:0] LIMIT =
      23'(365 * YP + YP / 4 - YP / 100 + YP / 400 + 365);

   typedef struct packed {
      logic [2:0]  mode;
      logic [1:0]  status;
      logic [22:0] na;
      logic [22:0] nb;
      logic [21:0] cnt;
   } front_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        have_date;
      logic [22:0] num;
      logic [21:0] count;
      logic [1:0]  order;
   } mid_type;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [21:0] count;
      logic [1:0]  order;
      logic [1:0]  status;
   } res_type;

   // Quotient by 100 of any 14-bit value, by multiplying with 5243 and shifting by 19;
   // the rounding error stays below 0.004, so the quotient is exact over this range.
   function automatic logic [13:0] div100(input logic [13:0] y);
      logic [26:0] prod;
      prod = 27'(y) * 27'd5243;
      return 14'(prod >> 19);
   endfunction

   function automatic logic is_leap(input logic [13:0] y);
      logic [13:0] q;
      logic        cent;
      q = div100(y);
      cent = (y == q * 14'd100);
      return ((y[1:0] == 2'd0) && !cent) || (cent && (q[1:0] == 2'd0));
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
      case (m)
         4'd2: month_days = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: month_days = 5'd30;
         default: month_days = 5'd31;
      endcase
   endfunction

   // Days before the first of month m.
   function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
      logic [8:0] t;
      case (m)
         4'd1: t = 9'd0;    4'd2: t = 9'd31;   4'd3: t = 9'd59;
         4'd4: t = 9'd90;   4'd5: t = 9'd120;  4'd6: t = 9'd151;
         4'd7: t = 9'd181;  4'd8: t = 9'd212;  4'd9: t = 9'd243;
         4'd10: t = 9'd273; 4'd11: t = 9'd304; default: t = 9'd334;
      endcase
      return t + 9'((leap && m > 4'd2) ? 1 : 0);
   endfunction

   function automatic logic date_ok(input logic [13:0] y, input logic [3:0] m,
                                    input logic [4:0] d);
      logic l;
      l = is_leap(y);
      return y >= 14'd1 && y <= 14'(MaxYear) && m >= 4'd1 && m <= 4'd12 &&
             d >= 5'd1 && d <= month_days(m, l);
   endfunction

endpackage
`default_nettype wire

>>> src/gda_to_number.sv
// Conversion of both dates to day numbers over one register stage, with validity checks.
`default_nettype none
module gda_to_number
   import gda_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        advance,
   input  wire logic [2:0]  mode,
   input  wire logic [13:0] year_a,
   input  wire logic [3:0]  month_a,
   input  wire logic [4:0]  day_a,
   input  wire logic [13:0] year_b,
   input  wire logic [3:0]  month_b,
   input  wire logic [4:0]  day_b,
   input  wire logic [21:0] day_count,
   output front_type        front
);

   logic [2:0]  mode_ff;
   logic [1:0]  status_ff, status_in;
   logic [21:0] cnt_ff;
   logic [22:0] ya_ff, yb_ff;
   logic [9:0]  ra_ff, rb_ff;
   logic [22:0] ya_in, yb_in;
   logic [9:0]  ra_in, rb_in;
   logic        oka, okb;

   // The whole years before year y as days: 365p + p/4 - p/100 + p/400.
   function automatic logic [22:0] year_days(input logic [13:0] y);
      logic [13:0] p;
      logic [13:0] q;
      p = y - 14'd1;
      q = div100(p);
      return 23'(p) * 23'd365 + 23'(p >> 2) - 23'(q) + 23'(q >> 2);
   endfunction

   always_comb begin
      oka = date_ok(year_a, month_a, day_a);
      okb = date_ok(year_b, month_b, day_b);
      ya_in = year_days(year_a);
      yb_in = year_days(year_b);
      ra_in = 10'(days_before(month_a, is_leap(year_a))) + 10'(day_a);
      rb_in = 10'(days_before(month_b, is_leap(year_b))) + 10'(day_b);
      status_in = ST_OK;
      case (mode)
         MODE_ADD, MODE_SUB, MODE_D2N: if (!oka) status_in = ST_BAD;
         MODE_DIFF: if (!oka || !okb) status_in = ST_BAD;
         MODE_N2D: status_in = ST_OK;
         default: status_in = ST_BAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode_ff <= mode;
         status_ff <= status_in;
         cnt_ff <= day_count;
         ya_ff <= ya_in;
         yb_ff <= yb_in;
         ra_ff <= ra_in;
         rb_ff <= rb_in;
      end
   end

   assign front.mode = mode_ff;
   assign front.status = status_ff;
   assign front.na = ya_ff + 23'(ra_ff);
   assign front.nb = yb_ff + 23'(rb_ff);
   assign front.cnt = cnt_ff;

endmodule
`default_nettype wire

>>> src/gda_to_date.sv
// Conversion of a day number back to a date over three register stages.
`default_nettype none
module gda_to_date
   import gda_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  advance,
   input  wire mid_type mid,
   output res_type    res
);

   // Stage A: 400- and 100-year blocks.
   logic [1:0]  sta_ff;
   logic        hda_ff;
   logic [21:0] cnta_ff;
   logic [1:0]  orda_ff;
   logic [13:0] yba_ff;
   logic [15:0] ra_ff;
   logic [22:0] z;
   logic [45:0] q400_prod;
   logic [5:0]  q400;
   logic [17:0] r400;
   logic [1:0]  c;
   logic [15:0] r100;

   // The quotient by 146097 comes from a reciprocal multiplication (scaled by 2^40);
   // it is exact for every day number up to the last day of the last year.
   always_comb begin
      z = mid.num - 23'd1;
      q400_prod = 46'(z) * 46'd7525902;
      q400 = 6'(q400_prod >> 40);
      r400 = 18'(z - 23'(q400) * 23'd146097);
      if (r400 >= 18'd109572) c = 2'd3;
      else if (r400 >= 18'd73048) c = 2'd2;
      else if (r400 >= 18'd36524) c = 2'd1;
      else c = 2'd0;
      r100 = 16'(r400 - 18'(c) * 18'd36524);
   end

   // Stage B: 4-year blocks and single years.
   logic [1:0]  stb_ff;
   logic        hdb_ff;
   logic [21:0] cntb_ff;
   logic [1:0]  ordb_ff;
   logic [13:0] ybb_ff;
   logic [8:0]  rb_ff;
   logic [31:0] q4_prod;
   logic [4:0]  q4;
   logic [10:0] r4;
   logic [1:0]  y1;
   logic [13:0] yb_in;

   // The quotient by 1461 is a reciprocal multiplication scaled by 2^26.
   always_comb begin
      q4_prod = 32'(ra_ff) * 32'd45934;
      q4 = 5'(q4_prod >> 26);
      r4 = 11'(ra_ff - 16'(q4) * 16'd1461);
      if (r4 >= 11'd1095) y1 = 2'd3;
      else if (r4 >= 11'd730) y1 = 2'd2;
      else if (r4 >= 11'd365) y1 = 2'd1;
      else y1 = 2'd0;
      yb_in = yba_ff + 14'(q4) * 14'd4 + 14'(y1) + 14'd1;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sta_ff <= mid.status; hda_ff <= mid.have_date;
         cnta_ff <= mid.count; orda_ff <= mid.order;
         yba_ff <= 14'(q400) * 14'd400 + 14'(c) * 14'd100;
         ra_ff <= r100;
         stb_ff <= sta_ff; hdb_ff <= hda_ff;
         cntb_ff <= cnta_ff; ordb_ff <= orda_ff;
         ybb_ff <= yb_in;
         rb_ff <= 9'(r4 - 11'(y1) * 11'd365);
      end
   end

   // Stage C: month search against the cumulative table.
   logic        leap;
   logic [3:0]  mo;
   logic [8:0]  month_start;
   res_type     res_in;

   always_comb begin
      leap = is_leap(ybb_ff);
      mo = 4'd1;
      for (int i = 2; i <= 12; i++) begin
         if (rb_ff >= days_before(4'(i), leap)) mo = 4'(i);
      end
      month_start = days_before(mo, leap);
      res_in.status = stb_ff;
      res_in.count = cntb_ff;
      res_in.order = ordb_ff;
      if (hdb_ff && stb_ff == ST_OK) begin
         res_in.year = ybb_ff;
         res_in.month = mo;
         res_in.day = 5'(rb_ff - month_start) + 5'd1;
      end else begin
         res_in.year = '0;
         res_in.month = '0;
         res_in.day = '0;
      end
   end

   res_type res_ff;
   always_ff @(posedge clock) begin
      if (advance) res_ff <= res_in;
   end
   assign res = res_ff;

endmodule
`default_nettype wire

>>> src/gregorian_date_arithmetic_top.sv
// Top level of the pipelined proleptic Gregorian date calculator.
// The block takes one beat per cycle while req_stall is low and returns one
// result beat per request, in order. There are five register stages: one to
// turn the dates into day numbers, one for the add, subtract or compare, three
// to turn a day number back into a date. The whole pipeline advances together
// when the result register is free or being taken, so a stall on rsp_stall
// holds every stage and loses nothing; req_stall is simply that hold. Modes 0
// and 1 add or subtract day_count, mode 2 gives the distance and order of two
// dates, mode 3 gives the day number of a date (0001-01-01 is day one) and
// mode 4 the date of a day number. An invalid date gives status 1, a result
// outside years 1 to 9999 gives status 2, and any error clears every other
// field.
`default_nettype none
module gregorian_date_arithmetic_top
   import gda_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_mode,
   input  wire logic [13:0] req_year_a,
   input  wire logic [3:0]  req_month_a,
   input  wire logic [4:0]  req_day_a,
   input  wire logic [13:0] req_year_b,
   input  wire logic [3:0]  req_month_b,
   input  wire logic [4:0]  req_day_b,
   input  wire logic [21:0] req_day_count,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [13:0]      rsp_res_year,
   output logic [3:0]       rsp_res_month,
   output logic [4:0]       rsp_res_day,
   output logic [21:0]      rsp_res_count,
   output logic [1:0]       rsp_order,
   output logic [1:0]       rsp_status
);

   localparam int Depth = 5;

   logic            advance;
   logic [Depth-1:0] valid_ff, valid_in;
   front_type       front;
   mid_type         mid_ff, mid_in;
   res_type         res;

   // The pipeline moves whenever the last stage is empty or being taken.
   assign advance = !valid_ff[Depth-1] || !rsp_stall;
   assign req_stall = !advance;
   assign valid_in = {valid_ff[Depth-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   gda_to_number u_num (
      .clock(clock), .advance(advance), .mode(req_mode),
      .year_a(req_year_a), .month_a(req_month_a), .day_a(req_day_a),
      .year_b(req_year_b), .month_b(req_month_b), .day_b(req_day_b),
      .day_count(req_day_count), .front(front)
   );

   // Middle stage: the day-number arithmetic and range checks.
   always_comb begin
      mid_in.status = front.status;
      mid_in.have_date = 1'b0;
      mid_in.num = 23'd1;
      mid_in.count = '0;
      mid_in.order = ORD_EQ;
      if (front.status == ST_OK) begin
         case (front.mode)
            MODE_ADD: begin
               if (front.na + 23'(front.cnt) > LIMIT) mid_in.status = ST_RANGE;
               else begin
                  mid_in.have_date = 1'b1;
                  mid_in.num = front.na + 23'(front.cnt);
               end
            end
            MODE_SUB: begin
               if (23'(front.cnt) >= front.na) mid_in.status = ST_RANGE;
               else begin
                  mid_in.have_date = 1'b1;
                  mid_in.num = front.na - 23'(front.cnt);
               end
            end
            MODE_DIFF: begin
               if (front.na > front.nb) begin
                  mid_in.count = 22'(front.na - front.nb);
                  mid_in.order = ORD_LATER;
               end else if (front.na < front.nb) begin
                  mid_in.count = 22'(front.nb - front.na);
                  mid_in.order = ORD_EARLY;
               end
            end
            MODE_D2N: mid_in.count = 22'(front.na);
            MODE_N2D: begin
               if (front.cnt == 22'd0 || 23'(front.cnt) > LIMIT) mid_in.status = ST_RANGE;
               else begin
                  mid_in.have_date = 1'b1;
                  mid_in.num = 23'(front.cnt);
               end
            end
            default: mid_in.status = ST_BAD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (advance) mid_ff <= mid_in;
   end

   gda_to_date u_date (.clock(clock), .advance(advance), .mid(mid_ff), .res(res));

   assign rsp_valid = valid_ff[Depth-1];
   assign rsp_res_year = res.year;
   assign rsp_res_month = res.month;
   assign rsp_res_day = res.day;
   assign rsp_res_count = res.count;
   assign rsp_order = res.order;
   assign rsp_status = res.status;

   a_err_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_res_year == 14'd0 && rsp_res_count == 22'd0)
      else $error("error result carries data");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_res_count))
      else $error("stalled result changed");
   a_pass: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[0])
      else $error("accepted beat lost");

endmodule
`default_nettype wire
